/* hdl/leib_pkg.sv */
`timescale 1ns / 1ps

package leib_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 256;

  // Operation selector carried in tuser.
  localparam logic [2:0] FUNC_KEY   = 3'd0;
  localparam logic [2:0] FUNC_LEFT  = 3'd1;
  localparam logic [2:0] FUNC_RIGHT = 3'd2;
  localparam logic [2:0] FUNC_READ  = 3'd3;
  localparam logic [2:0] FUNC_CLEAR = 3'd4;

  localparam logic [7:0] KEY_BACKSPACE = 8'd8;
  localparam logic [7:0] KEY_NEWLINE   = 8'd10;

  localparam logic [1:0] ECHO_NONE  = 2'd0;
  localparam logic [1:0] ECHO_CHAR  = 2'd1;
  localparam logic [1:0] ECHO_LEFT  = 2'd2;
  localparam logic [1:0] ECHO_RIGHT = 2'd3;

  // Command broadcast from the controller to every storage cell.
  typedef struct packed {
    logic       shift_en;
    logic       shift_left;
    logic       wr_en;
    logic [7:0] wr_data;
  } leib_cmd_t;

  // One result item; read_char sits in the lowest bits.
  typedef struct packed {
    logic       key_dropped;
    logic       line_committed;
    logic [7:0] echo_char;
    logic [1:0] echo_action;
    logic       read_valid;
    logic [7:0] read_char;
  } leib_res_t;

endpackage

/* hdl/leib_cell.sv */
`timescale 1ns / 1ps

module leib_cell #(
  parameter int unsigned STORE_DEPTH = 256,
  parameter int unsigned IDX         = 0
) (
  input  logic                              clk_i,
  input  leib_pkg::leib_cmd_t               cmd_i,
  input  logic [$clog2(STORE_DEPTH)-1:0]    lo_i,
  input  logic [$clog2(STORE_DEPTH)-1:0]    hi_i,
  input  logic [$clog2(STORE_DEPTH)-1:0]    wr_idx_i,
  input  logic [$clog2(STORE_DEPTH)-1:0]    rd_idx_i,
  input  logic [7:0]                        left_i,
  input  logic [7:0]                        right_i,
  input  logic [7:0]                        rd_prev_i,
  output logic [7:0]                        data_o,
  output logic [7:0]                        rd_o
);
  import leib_pkg::*;

  localparam int unsigned IW = $clog2(STORE_DEPTH);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [7:0] data_q, data_d;
  logic [7:0] rd_q, rd_d;
  logic       in_rng;

  // Membership in the ring interval [lo, hi); equal bounds mean empty.
  always_comb begin
    if (lo_i <= hi_i) begin
      in_rng = (lo_i <= MY_IDX) && (MY_IDX < hi_i);
    end else begin
      in_rng = (MY_IDX >= lo_i) || (MY_IDX < hi_i);
    end
  end

  always_comb begin
    data_d = data_q;
    if (cmd_i.wr_en && (wr_idx_i == MY_IDX)) begin
      data_d = cmd_i.wr_data;
    end else if (cmd_i.shift_en && in_rng) begin
      data_d = cmd_i.shift_left ? right_i : left_i;
    end
  end

  // The read-out chain carries the selected byte toward the last cell.
  assign rd_d = (rd_idx_i == MY_IDX) ? data_q : rd_prev_i;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    rd_q   <= rd_d;
  end

  assign data_o = data_q;
  assign rd_o   = rd_q;

endmodule

/* hdl/leib_ctrl.sv */
`timescale 1ns / 1ps

module leib_ctrl #(
  parameter int unsigned STORE_DEPTH = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        in_func_i,
  input  logic [7:0]                        in_key_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_data_i,
  input  logic [7:0]                        chain_i,
  output leib_pkg::leib_cmd_t               cmd_o,
  output logic [$clog2(STORE_DEPTH)-1:0]    lo_o,
  output logic [$clog2(STORE_DEPTH)-1:0]    hi_o,
  output logic [$clog2(STORE_DEPTH)-1:0]    wr_idx_o,
  output logic [$clog2(STORE_DEPTH)-1:0]    rd_idx_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output leib_pkg::leib_res_t               out_res_o
);
  import leib_pkg::*;

  localparam int unsigned IW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x);
    wrap_inc = (x == IW'(STORE_DEPTH - 1)) ? '0 : x + IW'(1);
  endfunction

  function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] x);
    wrap_dec = (x == '0) ? IW'(STORE_DEPTH - 1) : x - IW'(1);
  endfunction

  logic [1:0]    state_q, state_d;
  logic [2:0]    func_q, func_d;
  logic [7:0]    key_q, key_d;
  logic [IW-1:0] ls_q, ls_d, le_q, le_d, ep_q, ep_d, rp_q, rp_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [IW-1:0] wcnt_q, wcnt_d;
  logic          echo_en_q, echo_en_d;
  leib_res_t     res_q, res_d;
  logic          out_valid_q, out_valid_d;
  leib_res_t     out_res_q, out_res_d;
  logic [CW-1:0] line_len;

  // Length of the edited line; committed bytes are fill minus this.
  assign line_len = CW'(le_q) - CW'(ls_q) + ((le_q < ls_q) ? CW'(STORE_DEPTH) : '0);

  assign echo_en_d = cfg_valid_i ? cfg_data_i : echo_en_q;

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    key_d       = key_q;
    ls_d        = ls_q;
    le_d        = le_q;
    ep_d        = ep_q;
    rp_d        = rp_q;
    fill_d      = fill_q;
    wcnt_d      = wcnt_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    cmd_o       = '0;
    lo_o        = '0;
    hi_o        = '0;
    wr_idx_o    = ep_q;
    in_ready_o  = (state_q == ST_IDLE);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d  = in_func_i;
          key_d   = in_key_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_d   = '0;
        state_d = ST_RESULT;
        unique case (func_q)
          FUNC_KEY: begin
            priority if (key_q == KEY_BACKSPACE) begin
              if (ep_q != ls_q) begin
                cmd_o.shift_en   = 1'b1;
                cmd_o.shift_left = 1'b1;
                lo_o             = wrap_dec(ep_q);
                hi_o             = wrap_dec(le_q);
                ep_d             = wrap_dec(ep_q);
                le_d             = wrap_dec(le_q);
                if (fill_q != '0) begin
                  fill_d = fill_q - CW'(1);
                end
                res_d.echo_action = ECHO_CHAR;
                res_d.echo_char   = key_q;
              end
            end else if (key_q == KEY_NEWLINE) begin
              if (fill_q != CW'(STORE_DEPTH)) begin
                cmd_o.wr_en          = 1'b1;
                cmd_o.wr_data        = key_q;
                wr_idx_o             = le_q;
                le_d                 = wrap_inc(le_q);
                ls_d                 = wrap_inc(le_q);
                ep_d                 = wrap_inc(le_q);
                fill_d               = fill_q + CW'(1);
                res_d.line_committed = 1'b1;
                res_d.echo_action    = ECHO_CHAR;
                res_d.echo_char      = key_q;
              end else begin
                res_d.key_dropped = 1'b1;
              end
            end else begin
              if (fill_q < CW'(STORE_DEPTH - 1)) begin
                // Tail moves one slot right while the key lands at the edit point.
                cmd_o.shift_en = 1'b1;
                cmd_o.wr_en    = 1'b1;
                cmd_o.wr_data  = key_q;
                wr_idx_o       = ep_q;
                lo_o           = wrap_inc(ep_q);
                hi_o           = wrap_inc(le_q);
                ep_d           = wrap_inc(ep_q);
                le_d           = wrap_inc(le_q);
                fill_d         = fill_q + CW'(1);
              end else begin
                res_d.key_dropped = 1'b1;
              end
              res_d.echo_action = ECHO_CHAR;
              res_d.echo_char   = key_q;
            end
          end
          FUNC_LEFT: begin
            if (ep_q != ls_q) begin
              ep_d              = wrap_dec(ep_q);
              res_d.echo_action = ECHO_LEFT;
            end
          end
          FUNC_RIGHT: begin
            if (ep_q != le_q) begin
              ep_d              = wrap_inc(ep_q);
              res_d.echo_action = ECHO_RIGHT;
            end
          end
          FUNC_READ: begin
            if (fill_q > line_len) begin
              wcnt_d  = '0;
              state_d = ST_WAIT;
            end
          end
          FUNC_CLEAR: begin
            ls_d   = '0;
            le_d   = '0;
            ep_d   = '0;
            rp_d   = '0;
            fill_d = '0;
          end
          default: begin
          end
        endcase
        if (!echo_en_q) begin
          res_d.echo_action = ECHO_NONE;
          res_d.echo_char   = '0;
        end
      end
      ST_WAIT: begin
        // The byte at the read point reaches the chain tail within a full sweep.
        wcnt_d = wcnt_q + IW'(1);
        if (wcnt_q == IW'(STORE_DEPTH - 1)) begin
          res_d.read_char  = chain_i;
          res_d.read_valid = 1'b1;
          rp_d             = wrap_inc(rp_q);
          fill_d           = fill_q - CW'(1);
          state_d          = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rd_idx_o = rp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ls_q        <= '0;
      le_q        <= '0;
      ep_q        <= '0;
      rp_q        <= '0;
      fill_q      <= '0;
      wcnt_q      <= '0;
      echo_en_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ls_q        <= ls_d;
      le_q        <= le_d;
      ep_q        <= ep_d;
      rp_q        <= rp_d;
      fill_q      <= fill_d;
      wcnt_q      <= wcnt_d;
      echo_en_q   <= echo_en_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    key_q     <= key_d;
    res_q     <= res_d;
    out_res_q <= out_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

/* hdl/line_edit_input_buffer.sv */
`timescale 1ns / 1ps

// Channel   Direction  Contents
// s_axis    in         tuser: func[2:0]; tdata: key_char[7:0]
// m_axis    out        tdata: read_char, read_valid, echo_action, echo_char,
//                      line_committed, key_dropped (low bits first)
// cfg       in         data: echo_enable, always ready
//
// A key, edit or clear item passes the execute and result states to the
// output register; the store shifts its tail in a single step because
// every cell moves at once. A read of a committed byte waits while it
// travels the read-out chain to the last cell. Reset clears the pointers
// and the count, not the store. A stalled result holds in the output
// register. One more item is still taken and executed; its result waits
// in the controller, and later items wait until the output register frees.
module line_edit_input_buffer #(
  parameter int unsigned STORE_DEPTH = leib_pkg::STORE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // key_char[7:0]
  input  logic [2:0]  s_axis_tuser_i,   // func[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_char[7:0], read_valid[8], echo_action[10:9], echo_char[18:11],
  // line_committed[19], key_dropped[20], zero[23:21]
  output logic [23:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i        // echo_enable
);
  import leib_pkg::*;

  localparam int unsigned IW = $clog2(STORE_DEPTH);

  leib_cmd_t     cmd;
  leib_res_t     res;
  logic [IW-1:0] lo, hi, wr_idx, rd_idx;
  logic [7:0]    store_w [STORE_DEPTH];
  logic [7:0]    rd_w    [STORE_DEPTH];

  assign cfg_ready_o = 1'b1;

  leib_ctrl #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_func_i   (s_axis_tuser_i),
    .in_key_i    (s_axis_tdata_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .chain_i     (rd_w[STORE_DEPTH-1]),
    .cmd_o       (cmd),
    .lo_o        (lo),
    .hi_o        (hi),
    .wr_idx_o    (wr_idx),
    .rd_idx_o    (rd_idx),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    localparam int unsigned PREV = (i + STORE_DEPTH - 1) % STORE_DEPTH;
    localparam int unsigned NEXT = (i + 1) % STORE_DEPTH;

    logic [7:0] rd_prev;

    if (i == 0) begin : g_head
      assign rd_prev = 8'd0;
    end else begin : g_body
      assign rd_prev = rd_w[PREV];
    end

    leib_cell #(
      .STORE_DEPTH (STORE_DEPTH),
      .IDX         (i)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .lo_i      (lo),
      .hi_i      (hi),
      .wr_idx_i  (wr_idx),
      .rd_idx_i  (rd_idx),
      .left_i    (store_w[PREV]),
      .right_i   (store_w[NEXT]),
      .rd_prev_i (rd_prev),
      .data_o    (store_w[i]),
      .rd_o      (rd_w[i])
    );
  end

  assign m_axis_tdata_o = {3'b000, res};

endmodule

/* sim/tb_line_edit_input_buffer.sv */
`timescale 1ns / 1ps

import leib_pkg::*;

class line_buf_scoreboard;
  logic [7:0]  store [STORE_DEPTH_DEF];
  int unsigned line_start;
  int unsigned line_end;
  int unsigned edit_point;
  int unsigned read_point;
  int unsigned fill_count;
  bit          echo_en;
  leib_res_t   expected_q [$];
  int unsigned error_count;
  int unsigned result_count;
  int unsigned bytes_read;
  int unsigned lines_committed;
  int unsigned keys_dropped;
  int unsigned peak_fill;

  function new();
    foreach (store[i]) store[i] = 8'h00;
    line_start      = 0;
    line_end        = 0;
    edit_point      = 0;
    read_point      = 0;
    fill_count      = 0;
    echo_en         = 1'b1;
    error_count     = 0;
    result_count    = 0;
    bytes_read      = 0;
    lines_committed = 0;
    keys_dropped    = 0;
    peak_fill       = 0;
  endfunction

  function int unsigned wrap_next(int unsigned x);
    return (x + 1) % STORE_DEPTH_DEF;
  endfunction

  function int unsigned wrap_prev(int unsigned x);
    return (x + STORE_DEPTH_DEF - 1) % STORE_DEPTH_DEF;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  // Updates the buffer state for one accepted input and queues its result.
  function void note_input(logic [2:0] func, logic [7:0] key);
    leib_res_t   res;
    int unsigned pos;
    int unsigned nxt;
    res = '0;
    case (func)
      FUNC_KEY: begin
        if (key == KEY_BACKSPACE) begin
          if (edit_point != line_start) begin
            pos = wrap_prev(edit_point);
            nxt = edit_point;
            while (nxt != line_end) begin
              store[pos] = store[nxt];
              pos = nxt;
              nxt = wrap_next(pos);
            end
            edit_point = wrap_prev(edit_point);
            line_end   = wrap_prev(line_end);
            if (fill_count > 0) fill_count--;
            res.echo_action = ECHO_CHAR;
            res.echo_char   = key;
          end
        end else if (key == KEY_NEWLINE) begin
          if (fill_count < STORE_DEPTH_DEF) begin
            store[line_end] = key;
            line_end   = wrap_next(line_end);
            fill_count++;
            line_start = line_end;
            edit_point = line_end;
            res.line_committed = 1'b1;
            res.echo_action    = ECHO_CHAR;
            res.echo_char      = key;
            lines_committed++;
          end else begin
            res.key_dropped = 1'b1;
            keys_dropped++;
          end
        end else begin
          // A plain key never takes the last free slot, so that a newline can close the line.
          if (fill_count < STORE_DEPTH_DEF - 1) begin
            pos = line_end;
            while (pos != edit_point) begin
              nxt = wrap_prev(pos);
              store[pos] = store[nxt];
              pos = nxt;
            end
            store[edit_point] = key;
            edit_point = wrap_next(edit_point);
            line_end   = wrap_next(line_end);
            fill_count++;
          end else begin
            res.key_dropped = 1'b1;
            keys_dropped++;
          end
          res.echo_action = ECHO_CHAR;
          res.echo_char   = key;
        end
      end
      FUNC_LEFT: begin
        if (edit_point != line_start) begin
          edit_point = wrap_prev(edit_point);
          res.echo_action = ECHO_LEFT;
        end
      end
      FUNC_RIGHT: begin
        if (edit_point != line_end) begin
          edit_point = wrap_next(edit_point);
          res.echo_action = ECHO_RIGHT;
        end
      end
      FUNC_READ: begin
        if (fill_count > (line_end + STORE_DEPTH_DEF - line_start) % STORE_DEPTH_DEF) begin
          res.read_char  = store[read_point];
          res.read_valid = 1'b1;
          read_point = wrap_next(read_point);
          fill_count--;
          bytes_read++;
        end
      end
      FUNC_CLEAR: begin
        line_start = 0;
        line_end   = 0;
        edit_point = 0;
        read_point = 0;
        fill_count = 0;
      end
      default: ;
    endcase
    if (!echo_en) begin
      res.echo_action = ECHO_NONE;
      res.echo_char   = 8'h00;
    end
    if (fill_count > peak_fill) peak_fill = fill_count;
    expected_q.push_back(res);
  endfunction

  function void check_result(logic [23:0] data);
    leib_res_t got;
    leib_res_t want;
    got = data[20:0];
    result_count++;
    if (expected_q.size() == 0) begin
      error_count++;
      if (error_count <= 10)
        $display("ERROR: result %06h arrived with nothing pending", data);
      return;
    end
    want = expected_q.pop_front();
    if (got.read_char !== want.read_char || got.read_valid !== want.read_valid ||
        got.echo_action !== want.echo_action || got.echo_char !== want.echo_char ||
        got.line_committed !== want.line_committed ||
        got.key_dropped !== want.key_dropped || data[23:21] !== 3'b000) begin
      error_count++;
      if (error_count <= 10) begin
        $display("ERROR: result %0d want rc=%02h rv=%0b act=%0d ec=%02h lc=%0b kd=%0b",
                 result_count, want.read_char, want.read_valid, want.echo_action,
                 want.echo_char, want.line_committed, want.key_dropped);
        $display("       got rc=%02h rv=%0b act=%0d ec=%02h lc=%0b kd=%0b pad=%03b",
                 got.read_char, got.read_valid, got.echo_action, got.echo_char,
                 got.line_committed, got.key_dropped, data[23:21]);
      end
    end
  endfunction
endclass

module tb_line_edit_input_buffer;
  localparam int unsigned DEPTH        = STORE_DEPTH_DEF;
  localparam int unsigned DRAIN_CYCLES = DEPTH + 8;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic [2:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_data_i;

  line_buf_scoreboard sb;
  bit          src_idle;
  bit          sink_idle;
  int unsigned stim_items  = 0;
  int unsigned cycle_count = 0;

  line_edit_input_buffer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge of the transfer with tvalid still high.
  task automatic send_item(input logic [2:0] func, input logic [7:0] key);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) src_idle = !src_idle;
    gap = src_idle ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= key;
    s_axis_tuser_i  <= func;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_input(func, key);
    if (func <= FUNC_CLEAR) stim_items++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_echo(input bit value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.echo_en = value;
  endtask

  function automatic logic [7:0] plain_key();
    logic [7:0] k;
    k = 8'($urandom_range(0, 255));
    if (k == KEY_BACKSPACE || k == KEY_NEWLINE) k = k | 8'h40;
    return k;
  endfunction

  task automatic edit_line();
    int unsigned n;
    int unsigned pick;
    n = $urandom_range(1, 24);
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) send_item(FUNC_KEY, plain_key());
      else if (pick == 6) send_item(FUNC_LEFT, 8'($urandom_range(0, 255)));
      else if (pick == 7) send_item(FUNC_RIGHT, 8'($urandom_range(0, 255)));
      else send_item(FUNC_KEY, KEY_BACKSPACE);
    end
    // Now and then the line is left open and later traffic lands in it.
    if ($urandom_range(0, 9) != 0) send_item(FUNC_KEY, KEY_NEWLINE);
  endtask

  task automatic read_burst();
    int unsigned n;
    n = $urandom_range(1, 20);
    repeat (n) send_item(FUNC_READ, 8'($urandom_range(0, 255)));
  endtask

  // Drives the store to its limit, then empties it by reading or by a clear.
  task automatic fill_store(input bit empty_by_read);
    int unsigned k;
    while (sb.fill_count < DEPTH - 1) begin
      k = $urandom_range(0, 29);
      if (k == 0) send_item(FUNC_KEY, KEY_NEWLINE);
      else if (k == 1) send_item(FUNC_LEFT, 8'($urandom_range(0, 255)));
      else send_item(FUNC_KEY, plain_key());
    end
    repeat (2) send_item(FUNC_KEY, plain_key());
    send_item(FUNC_KEY, KEY_NEWLINE);
    send_item(FUNC_KEY, KEY_NEWLINE);
    send_item(FUNC_KEY, plain_key());
    send_item(FUNC_KEY, KEY_BACKSPACE);
    send_item(FUNC_RIGHT, 8'h00);
    send_item(FUNC_LEFT, 8'hFF);
    if (empty_by_read) repeat (DEPTH + 1) send_item(FUNC_READ, 8'($urandom_range(0, 255)));
    else send_item(FUNC_CLEAR, 8'($urandom_range(0, 255)));
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned start;
    int unsigned pick;
    start = stim_items;
    while (stim_items - start < count) begin
      pick = $urandom_range(0, 99);
      if (sb.fill_count > 180 && pick < 50) read_burst();
      else if (pick < 55) edit_line();
      else if (pick < 85) read_burst();
      else if (pick < 97) send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      else wait_idle();
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    m_axis_tready_i = 1'b0;
    sink_idle       = 1'b1;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_idle = !sink_idle;
      stall = sink_idle ? $urandom_range(0, 18) : 0;
      if (stall != 0) begin
        // Hold the result back once it shows up.
        m_axis_tready_i <= 1'b0;
        @(posedge clk_i);
        while (!m_axis_tvalid_o) @(posedge clk_i);
        repeat (stall - 1) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      sb.check_result(m_axis_tdata_o);
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    s_axis_tuser_i  = FUNC_KEY;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = 1'b0;
    src_idle        = 1'b1;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_echo(1'b1);
    send_item(FUNC_READ, 8'h00);
    send_item(FUNC_KEY, KEY_BACKSPACE);
    send_item(FUNC_LEFT, 8'hFF);
    send_item(FUNC_RIGHT, 8'h00);
    send_item(FUNC_KEY, 8'h00);
    send_item(FUNC_KEY, 8'hFF);
    send_item(FUNC_KEY, 8'h41);
    send_item(FUNC_LEFT, 8'h00);
    send_item(FUNC_LEFT, 8'h00);
    send_item(FUNC_KEY, 8'h7A);
    send_item(FUNC_RIGHT, 8'h00);
    send_item(FUNC_KEY, KEY_BACKSPACE);
    send_item(FUNC_KEY, KEY_NEWLINE);
    repeat (4) send_item(FUNC_READ, 8'hFF);
    send_item(3'd5, 8'hFF);
    send_item(3'd7, 8'h00);
    send_item(3'd6, 8'hA5);
    send_item(FUNC_KEY, 8'h71);
    send_item(FUNC_CLEAR, 8'h5A);
    send_item(FUNC_READ, 8'h00);

    write_echo(1'b0);
    fill_store(1'b1);
    run_random(150);
    write_echo(1'b1);
    run_random(300);
    fill_store(1'b0);
    write_echo(1'b0);
    run_random(250);
    write_echo(1'b1);
    run_random(250);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Summary: %0d commands, %0d results checked, %0d bytes read back, %0d lines committed",
             stim_items, sb.result_count, sb.bytes_read, sb.lines_committed);
    $display("Summary: %0d keys dropped, peak fill %0d of %0d, echo switched on and off",
             sb.keys_dropped, sb.peak_fill, DEPTH);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

/* filelist.f */
hdl/leib_pkg.sv
hdl/leib_cell.sv
hdl/leib_ctrl.sv
hdl/line_edit_input_buffer.sv
sim/tb_line_edit_input_buffer.sv
